[rtl/core/triangle_plane_slice_unit_macros.svh]
// Assertion macros for the triangle plane slice unit.
// Expects signals clk and arst_n in the scope of use.
`ifndef TRIANGLE_PLANE_SLICE_UNIT_MACROS_SVH
`define TRIANGLE_PLANE_SLICE_UNIT_MACROS_SVH

// Same-cycle implication, idle during reset
`define TPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, idle during reset
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tps_pkg.sv]
// Shared types and constants for the triangle plane slice unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

	localparam int COORD_WIDTH = 32;
	// interpolator depth: multiply, one stage per quotient bit, round
	localparam int INTERP_LAT  = COORD_WIDTH + 2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [COORD_WIDTH-1:0]        umag_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t az;
		coord_t bx;
		coord_t by_coord;
		coord_t bz;
		coord_t cx;
		coord_t cy;
		coord_t cz;
		coord_t plane_z;
	} triangle_t;

	typedef struct packed {
		logic   hit;
		coord_t x_first;
		coord_t y_first;
		coord_t x_second;
		coord_t y_second;
	} segment_t;

	// one crossing edge, both coordinates
	typedef struct packed {
		umag_t  num;
		umag_t  den;
		umag_t  mag_x;
		logic   neg_x;
		coord_t base_x;
		umag_t  mag_y;
		logic   neg_y;
		coord_t base_y;
	} edge_t;

	// operands of one interpolation
	typedef struct packed {
		umag_t  num;
		umag_t  den;
		umag_t  mag;
		logic   neg;
		coord_t base;
	} interp_op_t;

endpackage

`default_nettype wire

[rtl/core/tps_front.sv]
// Edge test and crossing selection: two pipeline stages.
// Depends on tps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tps_front (
	input  wire logic              clk,
	input  wire logic              en,
	input  tps_pkg::triangle_t     triangle,
	output logic                   hit_s2,
	output tps_pkg::edge_t         first_s2,
	output tps_pkg::edge_t         second_s2
);
	import tps_pkg::*;

	coord_t x [3];
	coord_t y [3];
	coord_t z [3];
	coord_t zp;

	edge_t  edge_c  [3];
	logic   cross_c [3];
	edge_t  edge_s1 [3];
	logic   cross_s1 [3];

	logic [1:0] cnt;
	edge_t      first_c;
	edge_t      second_c;

	assign x[0] = triangle.ax;
	assign y[0] = triangle.ay;
	assign z[0] = triangle.az;
	assign x[1] = triangle.bx;
	assign y[1] = triangle.by_coord;
	assign z[1] = triangle.bz;
	assign x[2] = triangle.cx;
	assign y[2] = triangle.cy;
	assign z[2] = triangle.cz;
	assign zp   = triangle.plane_z;

	// test each edge for a strict crossing and form its differences
	for (genvar e = 0; e < 3; e++) begin : g_edge
		localparam int J = (e + 1) % 3;
		logic below_i;
		logic above_i;
		logic below_j;
		logic above_j;
		assign below_i = z[e] < zp;
		assign above_i = z[e] > zp;
		assign below_j = z[J] < zp;
		assign above_j = z[J] > zp;
		assign cross_c[e] = (below_i && above_j) || (above_i && below_j);
		assign edge_c[e].num    = below_i ? umag_t'(zp - z[e]) : umag_t'(z[e] - zp);
		assign edge_c[e].den    = below_i ? umag_t'(z[J] - z[e]) : umag_t'(z[e] - z[J]);
		assign edge_c[e].neg_x  = x[J] < x[e];
		assign edge_c[e].mag_x  = edge_c[e].neg_x ? umag_t'(x[e] - x[J])
		                                           : umag_t'(x[J] - x[e]);
		assign edge_c[e].base_x = x[e];
		assign edge_c[e].neg_y  = y[J] < y[e];
		assign edge_c[e].mag_y  = edge_c[e].neg_y ? umag_t'(y[e] - y[J])
		                                           : umag_t'(y[J] - y[e]);
		assign edge_c[e].base_y = y[e];
	end

	// stage one: hold edge results
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				edge_s1[e]  <= edge_c[e];
				cross_s1[e] <= cross_c[e];
			end
		end
	end

	// pick the first two crossings in edge order
	always_comb begin
		cnt      = 2'(cross_s1[0]) + 2'(cross_s1[1]) + 2'(cross_s1[2]);
		first_c  = cross_s1[0] ? edge_s1[0] : (cross_s1[1] ? edge_s1[1] : edge_s1[2]);
		second_c = (cross_s1[0] && cross_s1[1]) ? edge_s1[1] : edge_s1[2];
	end

	// stage two
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s2    <= (cnt == 2'd2);
			first_s2  <= first_c;
			second_s2 <= second_c;
		end
	end

endmodule

`default_nettype wire

[rtl/core/tps_interp.sv]
// One coordinate interpolator: multiply, restoring divide one bit per stage,
// round and apply. Depends on tps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tps_interp (
	input  wire logic              clk,
	input  wire logic              en,
	input  tps_pkg::interp_op_t    op,
	output tps_pkg::coord_t        result
);
	import tps_pkg::*;

	localparam int W = COORD_WIDTH;

	// index 0 is the product stage, index k follows quotient bit k
	umag_t  r_p    [W+1];
	umag_t  lo_p   [W+1];
	umag_t  q_p    [W+1];
	umag_t  den_p  [W+1];
	logic   neg_p  [W+1];
	coord_t base_p [W+1];

	logic [2*W-1:0]      prod;
	logic                rnd;
	logic [W:0]          qq;
	logic signed [W+1:0] sum;
	coord_t              sat;
	coord_t              result_q;

	assign prod = (2*W)'(op.num) * (2*W)'(op.mag);

	// product stage
	always_ff @(posedge clk) begin
		if (en) begin
			r_p[0]    <= prod[2*W-1:W];
			lo_p[0]   <= prod[W-1:0];
			q_p[0]    <= '0;
			den_p[0]  <= op.den;
			neg_p[0]  <= op.neg;
			base_p[0] <= op.base;
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= W; k++) begin : g_div
		logic [W:0] t;
		logic       ge;
		logic [W:0] diff;
		assign t    = {r_p[k-1], lo_p[k-1][W-1]};
		assign ge   = t >= {1'b0, den_p[k-1]};
		assign diff = t - {1'b0, den_p[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				r_p[k]    <= ge ? diff[W-1:0] : t[W-1:0];
				lo_p[k]   <= {lo_p[k-1][W-2:0], 1'b0};
				q_p[k]    <= {q_p[k-1][W-2:0], ge};
				den_p[k]  <= den_p[k-1];
				neg_p[k]  <= neg_p[k-1];
				base_p[k] <= base_p[k-1];
			end
		end
	end

	// round half away from zero, apply sign, saturate
	always_comb begin
		rnd = {r_p[W], 1'b0} >= {1'b0, den_p[W]};
		qq  = {1'b0, q_p[W]} + (W+1)'(rnd);
		if (neg_p[W]) begin
			sum = (W+2)'(base_p[W]) - $signed({1'b0, qq});
		end else begin
			sum = (W+2)'(base_p[W]) + $signed({1'b0, qq});
		end
		if (sum > (W+2)'($signed({1'b0, {(W-1){1'b1}}}))) begin
			sat = {1'b0, {(W-1){1'b1}}};
		end else if (sum < $signed({{3{1'b1}}, {(W-1){1'b0}}})) begin
			sat = {1'b1, {(W-1){1'b0}}};
		end else begin
			sat = sum[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= sat;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

[rtl/core/triangle_plane_slice_unit.sv]
// Triangle plane slice unit: takes one triangle and a plane height per cycle while
// triangle_ready is high and returns the segment where the plane cuts it. Throughput
// is one item per cycle unless the skid stage stalls the pipe, set by the fully
// pipelined restoring dividers, one quotient bit per stage.
// Depends on tps_pkg, tps_front, tps_interp and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module triangle_plane_slice_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              triangle_valid,
	output logic                   triangle_ready,
	input  tps_pkg::triangle_t     triangle,
	output logic                   segment_valid,
	input  wire logic              segment_ready,
	output tps_pkg::segment_t      segment
);
	import tps_pkg::*;

	`include "triangle_plane_slice_unit_macros.svh"

	logic     en;
	logic     v_s1;
	logic     v_s2;
	logic     v_p   [INTERP_LAT];
	logic     hit_p [INTERP_LAT];
	logic     hit_s2;
	edge_t    first_s2;
	edge_t    second_s2;
	coord_t   xf;
	coord_t   yf;
	coord_t   xs;
	coord_t   ys;
	segment_t end_c;
	segment_t out_q;
	logic     out_valid_q;
	segment_t skid_q;
	logic     skid_valid_q;

	// advance the whole pipe while the skid stage is free
	assign en             = !skid_valid_q;
	assign triangle_ready = en;

	tps_front u_front (
		.clk       (clk),
		.en        (en),
		.triangle  (triangle),
		.hit_s2    (hit_s2),
		.first_s2  (first_s2),
		.second_s2 (second_s2)
	);

	tps_interp u_xf (
		.clk    (clk),
		.en     (en),
		.op     ('{first_s2.num, first_s2.den, first_s2.mag_x, first_s2.neg_x,
		          first_s2.base_x}),
		.result (xf)
	);

	tps_interp u_yf (
		.clk    (clk),
		.en     (en),
		.op     ('{first_s2.num, first_s2.den, first_s2.mag_y, first_s2.neg_y,
		          first_s2.base_y}),
		.result (yf)
	);

	tps_interp u_xs (
		.clk    (clk),
		.en     (en),
		.op     ('{second_s2.num, second_s2.den, second_s2.mag_x, second_s2.neg_x,
		          second_s2.base_x}),
		.result (xs)
	);

	tps_interp u_ys (
		.clk    (clk),
		.en     (en),
		.op     ('{second_s2.num, second_s2.den, second_s2.mag_y, second_s2.neg_y,
		          second_s2.base_y}),
		.result (ys)
	);

	// carry valid along the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < INTERP_LAT; k++) begin
				v_p[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1   <= triangle_valid;
			v_s2   <= v_s1;
			v_p[0] <= v_s2;
			for (int k = 1; k < INTERP_LAT; k++) begin
				v_p[k] <= v_p[k-1];
			end
		end
	end

	// carry the hit flag alongside the interpolators
	always_ff @(posedge clk) begin
		if (en) begin
			hit_p[0] <= hit_s2;
			for (int k = 1; k < INTERP_LAT; k++) begin
				hit_p[k] <= hit_p[k-1];
			end
		end
	end

	// drop the points when there is no segment
	always_comb begin
		end_c.hit      = hit_p[INTERP_LAT-1];
		end_c.x_first  = end_c.hit ? xf : '0;
		end_c.y_first  = end_c.hit ? yf : '0;
		end_c.x_second = end_c.hit ? xs : '0;
		end_c.y_second = end_c.hit ? ys : '0;
	end

	// output register with skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (segment_ready || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= en && v_p[INTERP_LAT-1];
				end
			end else if (en && v_p[INTERP_LAT-1]) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (segment_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : end_c;
		end else if (en && v_p[INTERP_LAT-1]) begin
			skid_q <= end_c;
		end
	end

	assign segment_valid = out_valid_q;
	assign segment       = out_q;

	`TPS_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
	`TPS_ASSERT_NEXT(a_skid_fill, !skid_valid_q && !(out_valid_q && !segment_ready), !skid_valid_q, "skid filled without stall")
	`TPS_ASSERT_NOW(a_miss_zero, segment_valid && !segment.hit, segment.x_first == '0 && segment.y_first == '0 && segment.x_second == '0 && segment.y_second == '0, "miss with nonzero points")

endmodule

`default_nettype wire

[verif/triangle_plane_slice_unit_tb.sv]
// Testbench for the triangle plane slice unit: directed table, then random triangles,
// each segment checked against an in-bench predictor of edge crossings and interpolation.
// Depends on tps_pkg and the triangle_plane_slice_unit RTL.
`timescale 1ns / 1ps

module triangle_plane_slice_unit_tb;
	import tps_pkg::*;

	localparam int RAND_TRIANGLES = 900;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 60;

	typedef struct {
		triangle_t shape;
		logic      has_seg;
		segment_t  seg;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      triangle_valid;
	logic      triangle_ready;
	triangle_t triangle;
	logic      segment_valid;
	logic      segment_ready;
	segment_t  segment;

	segment_t  expected_segments[$];
	int        error_count;
	int        idle_cycles;
	bit        stimulus_done;
	bit        long_hold_done;

	triangle_plane_slice_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.triangle_valid (triangle_valid),
		.triangle_ready (triangle_ready),
		.triangle       (triangle),
		.segment_valid  (segment_valid),
		.segment_ready  (segment_ready),
		.segment        (segment)
	);

	// clock: 8 ns period
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// round(num * mag / den), tie away from zero
	function automatic logic [63:0] scaled_offset(logic [63:0] num, logic [63:0] mag,
			logic [63:0] den);
		logic [127:0] prod;
		logic [127:0] q;
		logic [127:0] r;
		prod = num * mag;
		q = prod / den;
		r = prod % den;
		if (r >= den - r)
			q = q + 1;
		return q[63:0];
	endfunction

	// crossing coordinate on one edge
	function automatic coord_t edge_point(coord_t c1, coord_t c2, logic [63:0] num,
			logic [63:0] den);
		longint p1;
		longint p2;
		logic [63:0] mag;
		logic [63:0] off;
		longint res;
		p1 = c1;
		p2 = c2;
		mag = (p2 < p1) ? p1 - p2 : p2 - p1;
		off = scaled_offset(num, mag, den);
		res = (p2 < p1) ? p1 - longint'(off) : p1 + longint'(off);
		if (res > longint'(32'sh7fffffff))
			res = 32'sh7fffffff;
		if (res < -longint'(64'sh80000000))
			res = -longint'(64'sh80000000);
		return coord_t'(res);
	endfunction

	// predict the segment a triangle yields
	function automatic segment_t slice_triangle(triangle_t t);
		coord_t   vx[3];
		coord_t   vy[3];
		longint   vz[3];
		longint   pz;
		coord_t   px[2];
		coord_t   py[2];
		int       crossings;
		int       j;
		logic [63:0] num;
		logic [63:0] den;
		bit       crosses_plane;
		segment_t s;
		vx = '{t.ax, t.bx, t.cx};
		vy = '{t.ay, t.by_coord, t.cy};
		vz = '{longint'(t.az), longint'(t.bz), longint'(t.cz)};
		pz = t.plane_z;
		px = '{default: '0};
		py = '{default: '0};
		crossings = 0;
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			crosses_plane = 1'b1;
			if (vz[i] < pz && vz[j] > pz) begin
				num = pz - vz[i];
				den = vz[j] - vz[i];
			end else if (vz[i] > pz && vz[j] < pz) begin
				num = vz[i] - pz;
				den = vz[i] - vz[j];
			end else begin
				crosses_plane = 1'b0;
			end
			if (crosses_plane) begin
				if (crossings < 2) begin
					px[crossings] = edge_point(vx[i], vx[j], num, den);
					py[crossings] = edge_point(vy[i], vy[j], num, den);
				end
				crossings++;
			end
		end
		s = '0;
		if (crossings == 2) begin
			s.hit      = 1'b1;
			s.x_first  = px[0];
			s.y_first  = py[0];
			s.x_second = px[1];
			s.y_second = py[1];
		end
		return s;
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH %s at %0t", what, $realtime);
		error_count++;
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return coord_t'($urandom_range(0, 2000)) - 1000;
			default: return coord_t'($urandom);
		endcase
	endfunction

	// random triangle, mostly straddling the plane
	function automatic triangle_t rand_triangle();
		triangle_t t;
		t.ax = rand_coord();
		t.ay = rand_coord();
		t.bx = rand_coord();
		t.by_coord = rand_coord();
		t.cx = rand_coord();
		t.cy = rand_coord();
		t.plane_z = coord_t'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			t.plane_z = coord_t'($urandom_range(0, 1 << 24)) - (1 << 23);
			t.az = t.plane_z + coord_t'($urandom_range(0, 1 << 22)) - (1 << 21);
			t.bz = t.plane_z + coord_t'($urandom_range(0, 1 << 22)) - (1 << 21);
			t.cz = ($urandom_range(0, 7) == 0) ? t.plane_z : rand_coord();
		end else begin
			t.az = rand_coord();
			t.bz = rand_coord();
			t.cz = rand_coord();
		end
		return t;
	endfunction

	// drop valid and wait a random number of falling edges, mostly short
	task automatic random_gap();
		int n;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
			($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
		if (n > 0) begin
			triangle_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// offer one triangle and hold it until accepted
	task automatic send_triangle(triangle_t t);
		triangle_valid <= 1'b1;
		triangle <= t;
		@(posedge clk);
		while (!triangle_ready)
			@(posedge clk);
		expected_segments.insert(expected_segments.size(), slice_triangle(t));
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		stim_row_t rows[$];
		stim_row_t r;
		triangle_t t;
		segment_t  zero_seg;
		triangle_valid = 1'b0;
		triangle = '0;
		arst_n = 1'b0;
		error_count = 0;
		stimulus_done = 1'b0;
		zero_seg = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// flat triangle on the plane: nothing crosses
		r.shape = '{default: 32'sh0}; r.has_seg = 1'b1; r.seg = zero_seg;
		rows.insert(rows.size(), r);
		// all above
		r.shape = '{32'sh10000, 32'sh0, 32'sh50000, 32'sh0, 32'sh10000, 32'sh60000,
			32'sh20000, 32'sh20000, 32'sh70000, 32'sh0};
		rows.insert(rows.size(), r);
		// vertex on plane, opposite edge crossing: one crossing only
		r.shape = '{32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, -32'sh10000,
			32'sh0, 32'sh10000, 32'sh10000, 32'sh0};
		rows.insert(rows.size(), r);
		// simple symmetric cut at half height, exact midpoints
		r.shape = '{32'sh0, 32'sh0, -32'sh10000, 32'sh20000, 32'sh0, 32'sh10000,
			32'sh0, 32'sh20000, 32'sh10000, 32'sh0};
		r.has_seg = 1'b1;
		r.seg = '{1'b1, 32'sh10000, 32'sh0, 32'sh0, 32'sh10000};
		rows.insert(rows.size(), r);
		r.has_seg = 1'b0;
		// extreme coordinates and extreme heights
		r.shape = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh0};
		rows.insert(rows.size(), r);
		r.shape = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000001, 32'sh7fffffff, 32'sh80000000,
			32'sh80000000, 32'shffffffff};
		rows.insert(rows.size(), r);
		// tie rounding: offset of one half
		r.shape = '{32'sh0, 32'sh0, 32'sh0, 32'sh1, -32'sh1, 32'sh2,
			32'sh5, 32'sh5, -32'sh2, 32'sh1};
		rows.insert(rows.size(), r);
		r.shape = '{32'sh0, 32'sh0, 32'sh2, -32'sh1, 32'sh1, 32'sh0,
			32'sh3, -32'sh3, 32'sh4, 32'sh1};
		rows.insert(rows.size(), r);
		// all ones, then a plane just below the top limit
		r.shape = '{default: 32'shffffffff};
		rows.insert(rows.size(), r);
		r.shape = '{32'sh1234, 32'sh5678, 32'sh80000000, 32'sh9abc, 32'sh0def,
			32'sh7fffffff, 32'sh1111, 32'sh2222, 32'sh80000000, 32'sh7ffffffe};
		rows.insert(rows.size(), r);

		foreach (rows[i]) begin
			t = rows[i].shape;
			if (rows[i].has_seg && slice_triangle(t) !== rows[i].seg)
				report_mismatch($sformatf("table row %0d disagrees with predictor", i));
			send_triangle(t);
			random_gap();
		end

		// random triangles, with stretches of back-to-back items
		for (int i = 0; i < RAND_TRIANGLES; i++) begin
			send_triangle(rand_triangle());
			if (!(i >= 300 && i < 450))
				random_gap();
		end
		triangle_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// receiver: random stalls, one long hold-off while the sender keeps pushing
	initial begin
		segment_ready = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && expected_segments.size() > 5) begin
				segment_ready <= 1'b0;
				repeat (200) @(negedge clk);
				long_hold_done = 1'b1;
			end
			if ($urandom_range(0, 49) == 0) begin
				segment_ready <= 1'b0;
				repeat ($urandom_range(5, 30)) @(negedge clk);
			end
			segment_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// check each accepted segment against the oldest prediction
	always @(posedge clk) begin
		segment_t want;
		if (arst_n && segment_valid && segment_ready) begin
			if (expected_segments.size() == 0) begin
				report_mismatch($sformatf("unexpected segment %h", segment));
			end else begin
				want = expected_segments.pop_front();
				if (segment.hit !== want.hit)
					report_mismatch($sformatf("hit: got %h, want %h",
						segment.hit, want.hit));
				if (segment.x_first !== want.x_first)
					report_mismatch($sformatf("x_first: got %h, want %h",
						segment.x_first, want.x_first));
				if (segment.y_first !== want.y_first)
					report_mismatch($sformatf("y_first: got %h, want %h",
						segment.y_first, want.y_first));
				if (segment.x_second !== want.x_second)
					report_mismatch($sformatf("x_second: got %h, want %h",
						segment.x_second, want.x_second));
				if (segment.y_second !== want.y_second)
					report_mismatch($sformatf("y_second: got %h, want %h",
						segment.y_second, want.y_second));
			end
		end
	end

	// watchdog and end of run
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((triangle_valid && triangle_ready) || (segment_valid && segment_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
			if (stimulus_done && expected_segments.size() == 0) begin
				repeat (DRAIN_CYCLES) @(posedge clk);
				if (error_count == 0 && expected_segments.size() == 0) begin
					$display("DONE: 0 errors");
				end else begin
					$display("DONE: errors detected");
				end
				$finish;
			end
		end
	end

endmodule
